FILE: sv/fixed_pool_cell_allocator_top_macros.svh
// assertion macros used by the allocator datapath
`ifndef FIXED_POOL_CELL_ALLOCATOR_TOP_MACROS_SVH
`define FIXED_POOL_CELL_ALLOCATOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FPCA_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define FPCA_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define FPCA_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define FPCA_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: sv/fpca_pkg.sv
// types, constants and helpers of the cell allocator
package fpca_pkg;

  localparam int POOL_CELLS = 16;
  localparam int CELL_W     = (POOL_CELLS > 1) ? $clog2(POOL_CELLS) : 1;
  localparam int LINK_W     = $clog2(POOL_CELLS + 1);
  localparam int IDX_W      = 8;
  localparam int CMP_W      = IDX_W + 1;

  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_CELLS);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOT_USED = 2'd3
  } status_e;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] cell_index;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] granted_cell;
  } rsp_t;

  typedef struct packed {
    logic    load_req;
    logic    alloc_link;
    logic    alloc_head;
    logic    free_read;
    logic    free_unlink;
    logic    free_push;
    logic    load_rsp;
    status_e rsp_status;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
    logic pool_empty;
    logic range_err;
    logic not_used;
    logic out_ready;
  } dp_stat_t;

  function automatic logic is_cell(input logic [LINK_W-1:0] v);
    return v < LINK_W'(POOL_CELLS);
  endfunction

endpackage

FILE: sv/fixed_pool_cell_allocator_top.sv
// top level of the fixed pool cell allocator
// Allocates and frees cells of a pool of fpca_pkg::POOL_CELLS entries kept on
// a singly linked free list and a doubly linked in-use list. One request is
// worked at a time: after it is accepted, an allocate passes the states CHECK,
// A_LINK, A_HEAD and RESP, a free CHECK, F_READ, F_UNLINK, F_PUSH and RESP, and
// a rejected request (pool empty, index out of range, cell not in use) CHECK and
// RESP, where the result is loaded; the next request is taken the cycle after.
// Each list update step is one read or write per link store. A result that
// waits in the output register delays the next request only once that request
// is done.
module fixed_pool_cell_allocator_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  fpca_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output fpca_pkg::rsp_t out_data_o
);

  fpca_pkg::dp_cmd_t  cmd;
  fpca_pkg::dp_stat_t stat;

  fpca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fpca_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: sv/fpca_datapath.sv
// link stores, list heads and result register of the cell allocator
`include "fixed_pool_cell_allocator_top_macros.svh"
module fpca_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fpca_pkg::req_t     in_data_i,
  input  logic               out_stall_i,
  input  fpca_pkg::dp_cmd_t  cmd_i,
  output fpca_pkg::dp_stat_t stat_o,
  output logic               out_valid_o,
  output fpca_pkg::rsp_t     out_data_o
);

  logic [fpca_pkg::LINK_W-1:0] next_link_q [fpca_pkg::POOL_CELLS];
  logic [fpca_pkg::LINK_W-1:0] prev_link_q [fpca_pkg::POOL_CELLS];
  logic [fpca_pkg::POOL_CELLS-1:0] in_use_q;
  logic [fpca_pkg::LINK_W-1:0] free_head_q;
  logic [fpca_pkg::LINK_W-1:0] used_head_q;
  logic                        out_valid_q;

  logic                        mode_q;
  logic [fpca_pkg::IDX_W-1:0]  idx_q;
  logic [fpca_pkg::CELL_W-1:0] cell_q;
  logic [fpca_pkg::LINK_W-1:0] p_q;
  logic [fpca_pkg::LINK_W-1:0] n_q;
  fpca_pkg::rsp_t              out_q;

  logic [fpca_pkg::LINK_W-1:0] cell_link;
  logic                        out_ready;

  assign cell_link = fpca_pkg::LINK_W'(cell_q);
  assign out_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    stat_o.mode       = mode_q;
    stat_o.pool_empty = !fpca_pkg::is_cell(free_head_q);
    stat_o.range_err  = fpca_pkg::CMP_W'(idx_q) >= fpca_pkg::CMP_W'(fpca_pkg::POOL_CELLS);
    stat_o.not_used   = !in_use_q[cell_q];
    stat_o.out_ready  = out_ready;
  end

  // list state, one command at a time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fpca_pkg::POOL_CELLS; i++) begin
        next_link_q[i] <= (i + 1 < fpca_pkg::POOL_CELLS) ? fpca_pkg::LINK_W'(i + 1)
                                                          : fpca_pkg::LINK_NULL;
        prev_link_q[i] <= fpca_pkg::LINK_NULL;
      end
      in_use_q    <= '0;
      free_head_q <= '0;
      used_head_q <= fpca_pkg::LINK_NULL;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.alloc_link) begin
        free_head_q         <= next_link_q[cell_q];
        next_link_q[cell_q] <= used_head_q;
        prev_link_q[cell_q] <= fpca_pkg::LINK_NULL;
        in_use_q[cell_q]    <= 1'b1;
      end
      if (cmd_i.alloc_head) begin
        if (fpca_pkg::is_cell(used_head_q)) begin
          prev_link_q[used_head_q[fpca_pkg::CELL_W-1:0]] <= cell_link;
        end
        used_head_q <= cell_link;
      end
      if (cmd_i.free_unlink) begin
        if (fpca_pkg::is_cell(p_q)) begin
          next_link_q[p_q[fpca_pkg::CELL_W-1:0]] <= n_q;
        end else begin
          used_head_q <= n_q;
        end
        if (fpca_pkg::is_cell(n_q)) begin
          prev_link_q[n_q[fpca_pkg::CELL_W-1:0]] <= p_q;
        end
      end
      if (cmd_i.free_push) begin
        next_link_q[cell_q] <= free_head_q;
        prev_link_q[cell_q] <= fpca_pkg::LINK_NULL;
        free_head_q         <= cell_link;
        in_use_q[cell_q]    <= 1'b0;
      end
      if (cmd_i.load_rsp) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      mode_q <= in_data_i.mode;
      idx_q  <= in_data_i.cell_index;
      cell_q <= (in_data_i.mode == fpca_pkg::MODE_FREE)
                ? fpca_pkg::CELL_W'(in_data_i.cell_index)
                : free_head_q[fpca_pkg::CELL_W-1:0];
    end
    if (cmd_i.free_read) begin
      p_q <= prev_link_q[cell_q];
      n_q <= next_link_q[cell_q];
    end
    if (cmd_i.load_rsp) begin
      out_q.status       <= cmd_i.rsp_status;
      out_q.granted_cell <= (cmd_i.rsp_status == fpca_pkg::ST_OK &&
                             mode_q == fpca_pkg::MODE_ALLOC)
                            ? fpca_pkg::IDX_W'(cell_q) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a cell sits on exactly one list
  `FPCA_ASSERT_IMPLIES(a_heads_disjoint, clk_i, rst_ni,
    fpca_pkg::is_cell(free_head_q) && fpca_pkg::is_cell(used_head_q),
    free_head_q != used_head_q)
  `FPCA_ASSERT_IMPLIES(a_free_head_idle, clk_i, rst_ni, fpca_pkg::is_cell(free_head_q),
    !in_use_q[free_head_q[fpca_pkg::CELL_W-1:0]])
  `FPCA_ASSERT_IMPLIES(a_used_head_busy, clk_i, rst_ni, fpca_pkg::is_cell(used_head_q),
    in_use_q[used_head_q[fpca_pkg::CELL_W-1:0]])
  `FPCA_ASSERT_IMPLIES(a_grant_only_ok, clk_i, rst_ni,
    out_valid_q && out_q.granted_cell != '0, out_q.status == fpca_pkg::ST_OK)
  `FPCA_ASSERT_NEXT(a_alloc_marks_cell, clk_i, rst_ni, cmd_i.alloc_link,
    in_use_q[cell_q])

endmodule

FILE: sv/fpca_ctrl.sv
// request sequencer of the cell allocator
module fpca_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fpca_pkg::dp_stat_t stat_i,
  output fpca_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_CHECK    = 8'b0000_0010,
    S_A_LINK   = 8'b0000_0100,
    S_A_HEAD   = 8'b0000_1000,
    S_F_READ   = 8'b0001_0000,
    S_F_UNLINK = 8'b0010_0000,
    S_F_PUSH   = 8'b0100_0000,
    S_RESP     = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  fpca_pkg::status_e status_q, status_d;

  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    cmd_o.rsp_status = status_q;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_CHECK;
        end
      end
      S_CHECK: begin
        status_d = fpca_pkg::ST_OK;
        if (stat_i.mode == fpca_pkg::MODE_ALLOC) begin
          if (stat_i.pool_empty) begin
            status_d = fpca_pkg::ST_EMPTY;
            state_d  = S_RESP;
          end else begin
            state_d = S_A_LINK;
          end
        end else begin
          priority if (stat_i.range_err) begin
            status_d = fpca_pkg::ST_RANGE;
            state_d  = S_RESP;
          end else if (stat_i.not_used) begin
            status_d = fpca_pkg::ST_NOT_USED;
            state_d  = S_RESP;
          end else begin
            state_d = S_F_READ;
          end
        end
      end
      S_A_LINK: begin
        cmd_o.alloc_link = 1'b1;
        state_d          = S_A_HEAD;
      end
      S_A_HEAD: begin
        cmd_o.alloc_head = 1'b1;
        state_d          = S_RESP;
      end
      S_F_READ: begin
        cmd_o.free_read = 1'b1;
        state_d         = S_F_UNLINK;
      end
      S_F_UNLINK: begin
        cmd_o.free_unlink = 1'b1;
        state_d           = S_F_PUSH;
      end
      S_F_PUSH: begin
        cmd_o.free_push = 1'b1;
        state_d         = S_RESP;
      end
      S_RESP: begin
        // hold until the output register can take the item
        if (stat_i.out_ready) begin
          cmd_o.load_rsp = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= fpca_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

endmodule

FILE: test/fixed_pool_cell_allocator_top_test.sv
// self-checking testbench of the cell allocator with a linked-list pool predictor
module fixed_pool_cell_allocator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned RANDOM_ITEMS    = 680;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 20;

  class cell_pool_scoreboard;
    logic [fpca_pkg::LINK_W-1:0] link_next [fpca_pkg::POOL_CELLS];
    logic [fpca_pkg::LINK_W-1:0] link_prev [fpca_pkg::POOL_CELLS];
    bit                          cell_busy [fpca_pkg::POOL_CELLS];
    logic [fpca_pkg::LINK_W-1:0] free_top;
    logic [fpca_pkg::LINK_W-1:0] busy_top;
    fpca_pkg::rsp_t              expected_rsp_q [$];
    int unsigned                 mismatches;

    function void clear_pool();
      for (int i = 0; i < fpca_pkg::POOL_CELLS; i++) begin
        link_next[i] = (i + 1 < fpca_pkg::POOL_CELLS) ? fpca_pkg::LINK_W'(i + 1)
                                                      : fpca_pkg::LINK_NULL;
        link_prev[i] = fpca_pkg::LINK_NULL;
        cell_busy[i] = 1'b0;
      end
      free_top = '0;
      busy_top = fpca_pkg::LINK_NULL;
      expected_rsp_q.delete();
      mismatches = 0;
    endfunction

    function bit points_to_cell(logic [fpca_pkg::LINK_W-1:0] v);
      return v < fpca_pkg::LINK_W'(fpca_pkg::POOL_CELLS);
    endfunction

    // updates the pool lists and gives the response the block owes
    function fpca_pkg::rsp_t predict_response(fpca_pkg::req_t req);
      fpca_pkg::rsp_t              rsp;
      logic [fpca_pkg::LINK_W-1:0] c;
      logic [fpca_pkg::LINK_W-1:0] p;
      logic [fpca_pkg::LINK_W-1:0] n;
      rsp.status       = fpca_pkg::ST_OK;
      rsp.granted_cell = '0;
      if (req.mode == fpca_pkg::MODE_ALLOC) begin
        c = free_top;
        if (!points_to_cell(c)) begin
          rsp.status = fpca_pkg::ST_EMPTY;
        end else begin
          free_top     = link_next[c];
          link_next[c] = busy_top;
          link_prev[c] = fpca_pkg::LINK_NULL;
          if (points_to_cell(busy_top)) link_prev[busy_top] = c;
          busy_top         = c;
          cell_busy[c]     = 1'b1;
          rsp.granted_cell = fpca_pkg::IDX_W'(c);
        end
      end else if (req.cell_index >= fpca_pkg::IDX_W'(fpca_pkg::POOL_CELLS)) begin
        rsp.status = fpca_pkg::ST_RANGE;
      end else begin
        c = fpca_pkg::LINK_W'(req.cell_index);
        if (!cell_busy[c]) begin
          rsp.status = fpca_pkg::ST_NOT_USED;
        end else begin
          p = link_prev[c];
          n = link_next[c];
          if (points_to_cell(p)) link_next[p] = n;
          else busy_top = n;
          if (points_to_cell(n)) link_prev[n] = p;
          link_next[c] = free_top;
          link_prev[c] = fpca_pkg::LINK_NULL;
          free_top     = c;
          cell_busy[c] = 1'b0;
        end
      end
      return rsp;
    endfunction

    function void note_request(fpca_pkg::req_t req);
      expected_rsp_q.push_back(predict_response(req));
    endfunction

    function void check_response(fpca_pkg::rsp_t got);
      fpca_pkg::rsp_t want;
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: response mismatch: expected none actual status %0d cell %0d",
                 $time, got.status, got.granted_cell);
        mismatches++;
        return;
      end
      want = expected_rsp_q.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, want.status, got.status);
        mismatches++;
      end
      if (got.granted_cell !== want.granted_cell) begin
        $display("%0t: granted_cell mismatch: expected %0d actual %0d",
                 $time, want.granted_cell, got.granted_cell);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_rsp_q.size();
    endfunction

    // random cell with the wanted busy flag, -1 if there is none
    function int pick_cell(bit want_busy);
      int hits [$];
      for (int i = 0; i < fpca_pkg::POOL_CELLS; i++)
        if (cell_busy[i] == want_busy) hits.push_back(i);
      if (hits.size() == 0) return -1;
      return hits[$urandom_range(hits.size() - 1)];
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  fpca_pkg::req_t in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  fpca_pkg::rsp_t out_data;

  cell_pool_scoreboard sb;
  int unsigned         sent_count = 0;
  int unsigned         cycle_count = 0;
  bit                  hold_off_req = 1'b0;

  fixed_pool_cell_allocator_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic bit quiet_stretch();
    return sent_count >= 150 && sent_count < 330;
  endfunction

  task automatic send_request(input logic mode, input logic [fpca_pkg::IDX_W-1:0] idx);
    int unsigned    gap;
    fpca_pkg::req_t req;
    gap = 0;
    if (!quiet_stretch())
      while ($urandom_range(99) < 27) gap++;
    req.mode       = mode;
    req.cell_index = idx;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
    sent_count++;
  endtask

  task automatic wait_all_responses();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random_mix();
    bit fill_bias;
    int roll;
    int slot;
    fill_bias = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) fill_bias = !fill_bias;
      if (sent_count == 400) hold_off_req = 1'b1;
      if (sent_count == 550) wait_all_responses();
      roll = $urandom_range(99);
      if (roll < 15) begin
        // noise: out of range or idle-cell frees, allocs with junk index
        case ($urandom_range(2))
          0: send_request(fpca_pkg::MODE_FREE, fpca_pkg::IDX_W'($urandom_range(255)));
          1: begin
            slot = sb.pick_cell(1'b0);
            if (slot < 0)
              send_request(fpca_pkg::MODE_FREE, fpca_pkg::IDX_W'($urandom_range(255)));
            else send_request(fpca_pkg::MODE_FREE, fpca_pkg::IDX_W'(slot));
          end
          default: send_request(fpca_pkg::MODE_ALLOC, fpca_pkg::IDX_W'($urandom_range(255)));
        endcase
      end else if (roll < (fill_bias ? 75 : 40)) begin
        send_request(fpca_pkg::MODE_ALLOC, fpca_pkg::IDX_W'($urandom_range(255)));
      end else begin
        slot = sb.pick_cell(1'b1);
        if (slot < 0)
          send_request(fpca_pkg::MODE_ALLOC, fpca_pkg::IDX_W'($urandom_range(255)));
        else send_request(fpca_pkg::MODE_FREE, fpca_pkg::IDX_W'(slot));
      end
    end
  endtask

  initial begin
    sb = new;
    sb.clear_pool();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // free before anything was allocated
    send_request(fpca_pkg::MODE_FREE, fpca_pkg::IDX_W'(3));
    // drain the pool, then one allocate on an empty pool
    for (int i = 0; i <= fpca_pkg::POOL_CELLS; i++)
      send_request(fpca_pkg::MODE_ALLOC, fpca_pkg::IDX_W'($urandom_range(255)));
    send_request(fpca_pkg::MODE_FREE, '1);
    send_request(fpca_pkg::MODE_FREE, fpca_pkg::IDX_W'(fpca_pkg::POOL_CELLS));
    // middle of the in-use list, twice, then its head and its tail
    send_request(fpca_pkg::MODE_FREE, fpca_pkg::IDX_W'(5));
    send_request(fpca_pkg::MODE_FREE, fpca_pkg::IDX_W'(5));
    send_request(fpca_pkg::MODE_FREE, fpca_pkg::IDX_W'(fpca_pkg::POOL_CELLS - 1));
    send_request(fpca_pkg::MODE_FREE, '0);
    send_request(fpca_pkg::MODE_ALLOC, '0);

    send_random_mix();

    wait_all_responses();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // receiver: random stalls, a quiet stretch and one long hold-off
  initial begin
    int unsigned held;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        held = 0;
        while (held < HOLD_OFF_CYCLES) begin
          @(posedge clk);
          held++;
        end
        hold_off_req = 1'b0;
      end
      out_stall <= quiet_stretch() ? 1'b0 : ($urandom_range(99) < 27);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_response(out_data);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule

FILE: fixed_pool_cell_allocator_top.f
+incdir+sv
sv/fpca_pkg.sv
sv/fpca_datapath.sv
sv/fpca_ctrl.sv
sv/fixed_pool_cell_allocator_top.sv
test/fixed_pool_cell_allocator_top_test.sv
